FILE: src/cmtsd_pkg.sv
// Shared constants for the 24-minus-2 crank tooth decoder.
package cmtsd_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 6;

    localparam logic [COUNT_W-1:0] ROLLOVER_COUNT = 6'd25;
    localparam logic [COUNT_W-1:0] GAP_CHECK_A    = 6'd15;
    localparam logic [COUNT_W-1:0] GAP_CHECK_B    = 6'd23;
    localparam logic [COUNT_W-1:0] LONG_TOOTH_A   = 6'd14;
    localparam logic [COUNT_W-1:0] LONG_TOOTH_B   = 6'd22;
    localparam logic [COUNT_W-1:0] SYNC_RUN       = 6'd15;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 6'd63;
    localparam logic [COUNT_W-1:0] TOOTH_ONE      = 6'd1;
    localparam logic [COUNT_W-1:0] TEETH_PER_REV  = 6'd24;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_BITS   = 1 + COUNT_W + TIME_W + 1 + 1 + TIME_W + TIME_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

FILE: src/crank_missing_tooth_sync_decoder.sv
// Crank decoder for a 24-position wheel with two missing teeth.
// A result is offered once its edge request has passed the input register and then
// the result register, and is held there until it is taken.
// Throughput: one edge request per cycle while results are taken; the state update
// is combinational between the input register and the result register.
// Reset (i_rst_n low, synchronous): both stages empty, unsynced, all timing state zero.
module crank_missing_tooth_sync_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] edge_time
    input  logic [cmtsd_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] has_sync, [6:1] tooth_number, [38:7] tooth_gap, [39] sync_lost,
    // [40] revolution_valid, [72:41] revolution_time, [104:73] revolution_count,
    // [111:105] zero
    output logic [cmtsd_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int unsigned TW = cmtsd_pkg::TIME_W;
    localparam int unsigned CW = cmtsd_pkg::COUNT_W;

    // input stage
    logic          r_in_valid;
    logic [TW-1:0] r_edge_time;

    // decoder state
    logic [TW-1:0] r_last_edge_time, n_last_edge_time;
    logic [CW-1:0] r_tooth_counter, n_tooth_counter;
    logic [TW-1:0] r_reference_gap, n_reference_gap;
    logic          r_synced, n_synced;
    logic [TW-1:0] r_tooth_one_time, n_tooth_one_time;
    logic [TW-1:0] r_prev_tooth_one_time, n_prev_tooth_one_time;
    logic [TW-1:0] r_revolutions, n_revolutions;

    // result stage
    logic                               r_out_valid;
    logic [cmtsd_pkg::OUT_DATA_W-1:0]   r_out_data, n_out_data;

    logic          advance;
    logic [TW-1:0] gap;
    logic [TW-1:0] half_ref;
    logic [TW+1:0] gap_limit;
    logic          gap_small;
    logic [CW-1:0] count_inc;
    logic [TW-1:0] ref_x15;
    logic [TW-1:0] ref_x24;
    logic [TW-1:0] sync_tooth_one;
    logic          lost;
    logic          rev_valid;
    logic [TW-1:0] rev_time;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign gap       = r_edge_time - r_last_edge_time;
    assign half_ref  = {1'b0, r_reference_gap[TW-1:1]};
    // 1.5x reference at full width
    assign gap_limit = {2'b00, half_ref} + {1'b0, half_ref, 1'b0};
    assign gap_small = {2'b00, gap} < gap_limit;
    assign count_inc = r_tooth_counter + 1'b1;

    assign ref_x15        = {r_reference_gap[TW-5:0], 4'b0000} - r_reference_gap;
    assign ref_x24        = {r_reference_gap[TW-5:0], 4'b0000}
                          + {r_reference_gap[TW-4:0], 3'b000};
    assign sync_tooth_one = r_edge_time - ref_x15;

    always_comb begin
        n_last_edge_time      = r_edge_time;
        n_tooth_counter       = r_tooth_counter;
        n_reference_gap       = r_reference_gap;
        n_synced              = r_synced;
        n_tooth_one_time      = r_tooth_one_time;
        n_prev_tooth_one_time = r_prev_tooth_one_time;
        n_revolutions         = r_revolutions;
        lost                  = 1'b0;
        rev_valid             = 1'b0;
        rev_time              = '0;

        if (r_synced) begin
            n_tooth_counter = count_inc;
            if (count_inc == cmtsd_pkg::ROLLOVER_COUNT) begin
                n_tooth_counter       = cmtsd_pkg::TOOTH_ONE;
                n_prev_tooth_one_time = r_tooth_one_time;
                n_tooth_one_time      = r_edge_time;
                n_revolutions         = r_revolutions + 1'b1;
                rev_valid             = 1'b1;
                rev_time              = r_edge_time - r_tooth_one_time;
            end else if (count_inc == cmtsd_pkg::GAP_CHECK_B ||
                         count_inc == cmtsd_pkg::GAP_CHECK_A) begin
                // step over the missing position; drop sync if its gap is absent
                n_tooth_counter = count_inc + 1'b1;
                if (gap_small) begin
                    n_synced        = 1'b0;
                    n_tooth_counter = cmtsd_pkg::TOOTH_ONE;
                    lost            = 1'b1;
                end
            end else if (count_inc != cmtsd_pkg::LONG_TOOTH_A &&
                         count_inc != cmtsd_pkg::LONG_TOOTH_B) begin
                n_reference_gap = gap;
            end
        end else begin
            if (gap_small || r_reference_gap == '0) begin
                if (r_tooth_counter < cmtsd_pkg::COUNT_MAX) begin
                    n_tooth_counter = count_inc;
                end
                n_reference_gap = gap;
            end else if (r_tooth_counter == cmtsd_pkg::SYNC_RUN) begin
                n_synced              = 1'b1;
                n_tooth_counter       = cmtsd_pkg::SYNC_RUN + 1'b1;
                n_tooth_one_time      = sync_tooth_one;
                n_prev_tooth_one_time = sync_tooth_one - ref_x24;
            end else begin
                n_tooth_counter = cmtsd_pkg::TOOTH_ONE;
            end
        end

        n_out_data = {{(cmtsd_pkg::OUT_DATA_W - cmtsd_pkg::OUT_BITS){1'b0}},
                      n_revolutions, rev_time, rev_valid, lost, gap,
                      n_tooth_counter, n_synced};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_edge_time <= i_s_tdata[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge_time      <= '0;
            r_tooth_counter       <= '0;
            r_reference_gap       <= '0;
            r_synced              <= 1'b0;
            r_tooth_one_time      <= '0;
            r_prev_tooth_one_time <= '0;
            r_revolutions         <= '0;
        end else if (advance) begin
            r_last_edge_time      <= n_last_edge_time;
            r_tooth_counter       <= n_tooth_counter;
            r_reference_gap       <= n_reference_gap;
            r_synced              <= n_synced;
            r_tooth_one_time      <= n_tooth_one_time;
            r_prev_tooth_one_time <= n_prev_tooth_one_time;
            r_revolutions         <= n_revolutions;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    // synced tooth number stays within the wheel
    a_synced_tooth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_synced && r_in_valid) |-> (r_tooth_counter >= cmtsd_pkg::TOOTH_ONE &&
                                      r_tooth_counter <= cmtsd_pkg::TEETH_PER_REV))
        else $error("synced tooth counter out of range");

    // a lost sync leaves the decoder unsynced at tooth one
    a_lost_drops_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && lost) |=> (!r_synced && r_tooth_counter == cmtsd_pkg::TOOTH_ONE))
        else $error("sync loss did not reset the decoder");

    // a revolution only completes while synced, landing on tooth one
    a_rev_on_tooth_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && rev_valid) |=> (r_synced &&
                                    r_tooth_counter == cmtsd_pkg::TOOTH_ONE &&
                                    r_revolutions == $past(r_revolutions) + 1'b1))
        else $error("revolution reported away from tooth one");

    // state moves only when an edge is processed
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_tooth_counter) && $stable(r_synced) &&
                      $stable(r_last_edge_time)))
        else $error("decoder state changed without an edge");

endmodule
